// ----- sv/explosion_noise_generator_unit_macros.svh -----
// assertion macros shared by the checker
`ifndef EXPLOSION_NOISE_GENERATOR_UNIT_MACROS_SVH
`define EXPLOSION_NOISE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ENG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eng assertion failed");

// next-cycle implication, disabled while reset is high
`define ENG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eng assertion failed");

`endif

// ----- sv/eng_pkg.sv -----
package eng_pkg;

   // item codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_LATCH = 1'b1;

   localparam int RATE_W  = 18;
   localparam int COUNT_W = 19;
   localparam int ACC_W   = 21;
   localparam int LFSR_W  = 15;

   localparam int TICK_DECREMENT = 12000;
   localparam logic [ACC_W-1:0] NEG_DECREMENT = ACC_W'(-TICK_DECREMENT);

   localparam int TAP_HI  = 14;
   localparam int TAP_MID = 6;

   // ripple counter reload values picked by the pitch bits
   localparam logic [3:0] RELOAD_BASE = 4'd4;
   localparam logic [3:0] RELOAD_B6   = 4'd10;
   localparam logic [3:0] RELOAD_B7   = 4'd9;

   localparam logic [1:0] MAX_STEPS = 2'd2;

   typedef logic [ACC_W-1:0] acc_type;

   // resistor ladder levels (47k / 22k / 5k6 network), full scale 32766
   function automatic logic [15:0] eng_ladder(input logic [3:0] vol);
      logic [15:0] lvl;
      unique case (vol)
         4'd0:    lvl = 16'd0;
         4'd1:    lvl = 16'd2121;
         4'd2:    lvl = 16'd4532;
         4'd3:    lvl = 16'd6653;
         4'd4:    lvl = 16'd8308;
         4'd5:    lvl = 16'd10430;
         4'd6:    lvl = 16'd12840;
         4'd7:    lvl = 16'd14962;
         4'd8:    lvl = 16'd17804;
         4'd9:    lvl = 16'd19926;
         4'd10:   lvl = 16'd22336;
         4'd11:   lvl = 16'd24458;
         4'd12:   lvl = 16'd26113;
         4'd13:   lvl = 16'd28234;
         4'd14:   lvl = 16'd30645;
         default: lvl = 16'd32766;
      endcase
      return lvl;
   endfunction

endpackage

// ----- sv/explosion_noise_generator_unit.sv -----
// explosion noise voice
// req channel: one item per handshake; req_opcode selects a sample tick or a latch
//   write (req_latch_data: bits 5..2 volume, bits 7..6 pitch)
// a latch write gives no result and leaves req_ready high
// a tick walks a small sequencer around one shared 21-bit adder: ST_SUB takes
//   12000 off the rate counter, then ST_STEP runs up to two reload steps (each adds
//   csr_sample_rate and clocks the lfsr and ripple counter) and then sees the loop
//   end, and ST_DONE loads the result
// one tick at a time: a new request is not taken until the last tick's result has
//   been loaded, as req_ready is low while the adder loop runs
// rsp channel: a registered output stage; a stalled rsp_ready holds rsp_sample and
//   keeps the sequencer waiting in its final state, req_ready stays low meanwhile
// csr channel: csr_ready is always high, write only while the block is idle
// reset (synchronous, active high): sample rate 48000, divider, lfsr, ripple counter,
//   noise bit and latch cleared, no result pending
module explosion_noise_generator_unit
   import eng_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [7:0]          req_latch_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_sample,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [RATE_W-1:0]   csr_sample_rate
);

   // sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SUB  = 2'd1;
   localparam logic [1:0] ST_STEP = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [COUNT_W-1:0] counter_ff, counter_in;
   acc_type            acc_ff, acc_in;
   logic [1:0]         steps_ff, steps_in;
   logic [LFSR_W-1:0]  lfsr_ff, lfsr_in;
   logic [3:0]         ripple_ff, ripple_in;
   logic               noise_ff, noise_in;
   logic [7:0]         latch_ff, latch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_sample_ff, rsp_sample_in;

   // shared adder
   acc_type add_a, add_b, add_sum;
   logic    acc_le_zero;
   logic    do_step;

   // next lfsr / ripple values for one reload step
   logic [LFSR_W-1:0] lfsr_step;
   logic [3:0]        ripple_inc, ripple_step, ripple_reload;

   logic [15:0] level;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

   always_comb begin
      if (state_ff == ST_SUB) begin
         add_a = {{(ACC_W-COUNT_W){counter_ff[COUNT_W-1]}}, counter_ff};
         add_b = NEG_DECREMENT;
      end else begin
         add_a = acc_ff;
         add_b = {{(ACC_W-RATE_W){1'b0}}, rate_ff};
      end
      add_sum = add_a + add_b;
   end

   assign acc_le_zero = acc_ff[ACC_W-1] || (acc_ff == '0);
   assign do_step = acc_le_zero && (steps_ff != MAX_STEPS);

   // lfsr shifts left, feedback is xnor of the two taps
   assign lfsr_step = {lfsr_ff[LFSR_W-2:0], (lfsr_ff[TAP_HI] == lfsr_ff[TAP_MID])};

   always_comb begin
      ripple_reload = latch_ff[6] ? RELOAD_B6 : RELOAD_BASE;
      if (latch_ff[7]) begin
         ripple_reload = ripple_reload | RELOAD_B7;
      end
      ripple_inc = ripple_ff + 4'd1;
      ripple_step = (ripple_inc == 4'd0) ? ripple_reload : ripple_inc;
   end

   // output level, negated when the noise bit is low; volume 0 gives 0 either way
   assign level = eng_ladder(latch_ff[5:2]);

   always_comb begin
      state_in      = state_ff;
      rate_in       = rate_ff;
      counter_in    = counter_ff;
      acc_in        = acc_ff;
      steps_in      = steps_ff;
      lfsr_in       = lfsr_ff;
      ripple_in     = ripple_ff;
      noise_in      = noise_ff;
      latch_in      = latch_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;

      if (csr_valid) begin
         rate_in = csr_sample_rate;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_LATCH) begin
                  latch_in = req_latch_data;
               end else begin
                  state_in = ST_SUB;
               end
            end
         end
         ST_SUB: begin
            acc_in   = add_sum;
            steps_in = 2'd0;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (do_step) begin
               acc_in    = add_sum;
               steps_in  = steps_ff + 2'd1;
               lfsr_in   = lfsr_step;
               ripple_in = ripple_step;
               if (ripple_step == 4'hF) begin
                  noise_in = lfsr_step[0];
               end
            end else begin
               // wrap into the 19-bit counter
               counter_in = acc_ff[COUNT_W-1:0];
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = noise_ff ? level : (~level + 16'd1);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= RATE_W'(48000);
         counter_ff   <= '0;
         steps_ff     <= '0;
         lfsr_ff      <= '0;
         ripple_ff    <= '0;
         noise_ff     <= 1'b0;
         latch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         counter_ff   <= counter_in;
         steps_ff     <= steps_in;
         lfsr_ff      <= lfsr_in;
         ripple_ff    <= ripple_in;
         noise_ff     <= noise_in;
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
   end

endmodule

// ----- sv/eng_checker.sv -----
`include "explosion_noise_generator_unit_macros.svh"

module eng_checker
   import eng_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_opcode,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic signed [15:0]  rsp_sample
);

   logic rsp_stall;
   logic tick_take;
   logic latch_take;

   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign tick_take  = req_valid && req_ready && (req_opcode == OP_TICK);
   assign latch_take = req_valid && req_ready && (req_opcode == OP_LATCH);

   // a stalled result holds
   `ENG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_sample))

   // a tick occupies the sequencer
   `ENG_ASSERT_NEXT(a_tick_busy, clock, reset, tick_take, !req_ready)

   // a latch write gives no result
   `ENG_ASSERT_NEXT(a_latch_quiet, clock, reset, !rsp_valid && latch_take, !rsp_valid)

   // a new result only comes out of a busy sequencer
   `ENG_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

bind explosion_noise_generator_unit eng_checker u_eng_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_opcode (req_opcode),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_sample (rsp_sample)
);
